// File: design/cca_pkg.sv
package cca_pkg;

    localparam int unsigned SECS_IN_MIN    = 60;
    localparam int unsigned MINS_IN_HOUR   = 60;
    localparam int unsigned HOURS_IN_DAY   = 24;
    localparam int unsigned DAYS_IN_WEEK   = 7;
    localparam int unsigned MONTHS_IN_YEAR = 12;

    // year counter remainders kept beside the year for the leap rule
    localparam int unsigned YEAR_CENTURY   = 100;
    localparam int unsigned YEAR_CYCLE     = 400;

    // epoch used by force set and reset
    localparam logic [3:0] EPOCH_MONTH   = 4'd1;
    localparam logic [4:0] EPOCH_DAY     = 5'd1;
    localparam logic [2:0] EPOCH_WEEKDAY = 3'd6;

    localparam logic [5:0] SPT_RESET = 6'd1;

    typedef enum logic [2:0] {
        OP_ADVANCE   = 3'd0,
        OP_FWD_TIME  = 3'd1,
        OP_FWD_WDAY  = 3'd2,
        OP_TICK      = 3'd3,
        OP_FORCE_SET = 3'd4
    } t_op;

    localparam logic [3:0] CFG_SECONDS_PER_TICK = 4'd0;
    localparam logic [3:0] CFG_TIME_PAUSED      = 4'd1;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] day_count;
        logic [7:0]  hour_count;
        logic [7:0]  minute_count;
        logic [7:0]  second_count;
        logic [2:0]  target_weekday;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  clock_second;
        logic [5:0]  clock_minute;
        logic [4:0]  clock_hour;
        logic [4:0]  clock_day;
        logic [3:0]  clock_month;
        logic [15:0] clock_year;
        logic [2:0]  clock_weekday;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic add;
        logic norm_step;
        logic walk_step;
        logic publish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic time_norm;
        logic days_zero;
    } t_status;

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// File: design/cca_ctrl.sv
module cca_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  cca_pkg::t_status i_status,
    output cca_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_NORM,
        S_WALK,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_NORM;
            end
            S_NORM: begin
                o_cmd.norm_step = 1'b1;
                if (i_status.time_norm) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_status.days_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_DONE: begin
                // wait for the output slot to be free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: design/cca_dpath.sv
module cca_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cca_pkg::t_cmd      i_cmd,
    output cca_pkg::t_status   o_status,
    input  cca_pkg::t_in_item  i_item,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_index,
    input  logic [5:0]         i_cfg_data,
    output cca_pkg::t_out_item o_result
);

    // clock state
    logic [5:0]  r_sec;
    logic [5:0]  r_min;
    logic [4:0]  r_hour;
    logic [4:0]  r_day;
    logic [3:0]  r_month;
    logic [15:0] r_year;
    logic [2:0]  r_wday;
    logic [6:0]  r_ymod100;
    logic [8:0]  r_ymod400;

    // configuration
    logic [5:0]  r_spt;
    logic        r_paused;

    // working accumulators
    logic [8:0]  r_acc_s;
    logic [8:0]  r_acc_m;
    logic [8:0]  r_acc_h;
    logic [16:0] r_acc_d;

    cca_pkg::t_out_item r_out;

    // amounts to add, taken at load
    logic [7:0]        a_s, a_m, a_h;
    logic [15:0]       a_d;
    logic signed [9:0] v_ds, v_dm, v_dh;
    logic [2:0]        v_tw;
    logic [3:0]        v_wd_sum;
    cca_pkg::t_op      v_op;

    // month walk
    logic        v_leap;
    logic [4:0]  v_len;
    logic [4:0]  v_left;
    logic [5:0]  v_span;
    logic        v_cross;
    logic [5:0]  v_wd_in;
    logic [2:0]  n_wday;

    logic sec_ge, min_ge, hour_ge;

    function automatic logic [2:0] mod7(input logic [5:0] value);
        logic [5:0] v;
        v = value;
        // inputs stay at or below 37
        for (int i = 0; i < 5; i++) begin
            if (v >= 6'(cca_pkg::DAYS_IN_WEEK)) begin
                v = v - 6'(cca_pkg::DAYS_IN_WEEK);
            end
        end
        return v[2:0];
    endfunction

    assign v_op = cca_pkg::t_op'(i_item.operation);

    always_comb begin
        a_s      = '0;
        a_m      = '0;
        a_h      = '0;
        a_d      = '0;
        v_ds     = '0;
        v_dm     = '0;
        v_dh     = '0;
        v_tw     = '0;
        v_wd_sum = '0;
        case (v_op)
            cca_pkg::OP_ADVANCE, cca_pkg::OP_FORCE_SET: begin
                a_s = i_item.second_count;
                a_m = i_item.minute_count;
                a_h = i_item.hour_count;
                a_d = i_item.day_count;
            end
            cca_pkg::OP_FWD_TIME: begin
                // target minus current with borrows
                v_ds = $signed({2'b00, i_item.second_count}) - $signed({4'b0000, r_sec});
                v_dm = $signed({2'b00, i_item.minute_count}) - $signed({4'b0000, r_min});
                v_dh = $signed({2'b00, i_item.hour_count}) - $signed({5'b00000, r_hour});
                if (v_ds < 10'sd0) begin
                    v_ds = v_ds + 10'(cca_pkg::SECS_IN_MIN);
                    v_dm = v_dm - 10'sd1;
                end
                if (v_dm < 10'sd0) begin
                    v_dm = v_dm + 10'(cca_pkg::MINS_IN_HOUR);
                    v_dh = v_dh - 10'sd1;
                end
                if (v_dh < 10'sd0) begin
                    v_dh = v_dh + 10'(cca_pkg::HOURS_IN_DAY);
                end
                a_s = v_ds[7:0];
                a_m = v_dm[7:0];
                a_h = v_dh[7:0];
            end
            cca_pkg::OP_FWD_WDAY: begin
                // weekday code 7 reads as sunday
                v_tw = (i_item.target_weekday == 3'(cca_pkg::DAYS_IN_WEEK)) ?
                       3'd0 : i_item.target_weekday;
                v_wd_sum = {1'b0, v_tw} + 4'(cca_pkg::DAYS_IN_WEEK) - {1'b0, r_wday};
                if (v_wd_sum >= 4'(cca_pkg::DAYS_IN_WEEK)) begin
                    v_wd_sum = v_wd_sum - 4'(cca_pkg::DAYS_IN_WEEK);
                end
                a_d = {12'd0, v_wd_sum};
            end
            cca_pkg::OP_TICK: begin
                if (!r_paused) begin
                    a_s = {2'b00, r_spt};
                end
            end
            default: begin
            end
        endcase
    end

    assign sec_ge  = r_acc_s >= 9'(cca_pkg::SECS_IN_MIN);
    assign min_ge  = r_acc_m >= 9'(cca_pkg::MINS_IN_HOUR);
    assign hour_ge = r_acc_h >= 9'(cca_pkg::HOURS_IN_DAY);

    assign o_status.time_norm = !sec_ge && !min_ge && !hour_ge;
    assign o_status.days_zero = (r_acc_d == '0);

    always_comb begin
        v_leap  = ((r_year[1:0] == 2'b00) && (r_ymod100 != '0)) || (r_ymod400 == '0);
        v_len   = cca_pkg::month_days(r_month, v_leap);
        v_left  = (v_len > r_day) ? (v_len - r_day) : 5'd0;
        v_span  = {1'b0, v_left} + 6'd1;
        v_cross = r_acc_d > {12'd0, v_left};
        v_wd_in = v_cross ? v_span : {1'b0, r_acc_d[4:0]};
        n_wday  = mod7({3'b000, r_wday} + v_wd_in);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec     <= '0;
            r_min     <= '0;
            r_hour    <= '0;
            r_day     <= cca_pkg::EPOCH_DAY;
            r_month   <= cca_pkg::EPOCH_MONTH;
            r_year    <= '0;
            r_wday    <= cca_pkg::EPOCH_WEEKDAY;
            r_ymod100 <= '0;
            r_ymod400 <= '0;
            r_spt     <= cca_pkg::SPT_RESET;
            r_paused  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cca_pkg::CFG_SECONDS_PER_TICK: r_spt    <= i_cfg_data;
                    cca_pkg::CFG_TIME_PAUSED:      r_paused <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load && (v_op == cca_pkg::OP_FORCE_SET)) begin
                r_sec     <= '0;
                r_min     <= '0;
                r_hour    <= '0;
                r_day     <= cca_pkg::EPOCH_DAY;
                r_month   <= cca_pkg::EPOCH_MONTH;
                r_year    <= '0;
                r_wday    <= cca_pkg::EPOCH_WEEKDAY;
                r_ymod100 <= '0;
                r_ymod400 <= '0;
            end
            if (i_cmd.norm_step && o_status.time_norm) begin
                r_sec  <= r_acc_s[5:0];
                r_min  <= r_acc_m[5:0];
                r_hour <= r_acc_h[4:0];
            end
            if (i_cmd.walk_step) begin
                r_wday <= n_wday;
                if (v_cross) begin
                    r_day <= cca_pkg::EPOCH_DAY;
                    if (r_month >= 4'(cca_pkg::MONTHS_IN_YEAR)) begin
                        r_month <= cca_pkg::EPOCH_MONTH;
                        if (r_year == '1) begin
                            // year wraps to zero
                            r_year    <= '0;
                            r_ymod100 <= '0;
                            r_ymod400 <= '0;
                        end else begin
                            r_year    <= r_year + 16'd1;
                            r_ymod100 <= (r_ymod100 == 7'(cca_pkg::YEAR_CENTURY - 1)) ?
                                         7'd0 : r_ymod100 + 7'd1;
                            r_ymod400 <= (r_ymod400 == 9'(cca_pkg::YEAR_CYCLE - 1)) ?
                                         9'd0 : r_ymod400 + 9'd1;
                        end
                    end else begin
                        r_month <= r_month + 4'd1;
                    end
                end else begin
                    r_day <= r_day + r_acc_d[4:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc_s <= {1'b0, a_s};
            r_acc_m <= {1'b0, a_m};
            r_acc_h <= {1'b0, a_h};
            r_acc_d <= {1'b0, a_d};
        end
        if (i_cmd.add) begin
            r_acc_s <= r_acc_s + {3'b000, r_sec};
            r_acc_m <= r_acc_m + {3'b000, r_min};
            r_acc_h <= r_acc_h + {4'b0000, r_hour};
        end
        if (i_cmd.norm_step) begin
            // one carry per cycle, seconds first
            if (sec_ge) begin
                r_acc_s <= r_acc_s - 9'(cca_pkg::SECS_IN_MIN);
                r_acc_m <= r_acc_m + 9'd1;
            end else if (min_ge) begin
                r_acc_m <= r_acc_m - 9'(cca_pkg::MINS_IN_HOUR);
                r_acc_h <= r_acc_h + 9'd1;
            end else if (hour_ge) begin
                r_acc_h <= r_acc_h - 9'(cca_pkg::HOURS_IN_DAY);
                r_acc_d <= r_acc_d + 17'd1;
            end
        end
        if (i_cmd.walk_step) begin
            r_acc_d <= v_cross ? (r_acc_d - {11'd0, v_span}) : 17'd0;
        end
        if (i_cmd.publish) begin
            r_out.clock_second  <= r_sec;
            r_out.clock_minute  <= r_min;
            r_out.clock_hour    <= r_hour;
            r_out.clock_day     <= r_day;
            r_out.clock_month   <= r_month;
            r_out.clock_year    <= r_year;
            r_out.clock_weekday <= r_wday;
        end
    end

    assign o_result = r_out;

endmodule

// File: design/calendar_clock_advance_core.sv
// channel  | direction | handshake                        | payload
// ---------+-----------+----------------------------------+---------------------------------
// s_axis   | in        | i_s_axis_tvalid / o_s_axis_tready | tdata 48b, tuser 3b (operation)
// m_axis   | out       | o_m_axis_tvalid / i_m_axis_tready | tdata 48b clock fields
// cfg      | in        | i_cfg_valid / o_cfg_ready         | index 4b, data 6b
//
// one item at a time, in order: the accept, the add, one seconds, minutes or hours
// carry at a time (up to 21 carries) and then the commit of the time of day, one walk
// step per month boundary crossed and one for any days left in the last month, a check
// that sees the day count at zero and the load of the output register; the month walk sets the tail
// synchronous active-low reset: clock goes to 00:00:00 january 1 year 0 saturday,
// one second per tick, not paused
// the output register holds one result; the next item is accepted while it waits,
// and the finished item holds in the last state until the output slot frees
// cfg is always ready; it is to be written only while the block is idle, which the block does not enforce
module calendar_clock_advance_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // day_count[15:0], hour_count[23:16], minute_count[31:24],
    // second_count[39:32], target_weekday[42:40], zero[47:43]
    input  logic [47:0] i_s_axis_tdata,
    // operation[2:0]
    input  logic [2:0]  i_s_axis_tuser,

    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // clock_second[5:0], clock_minute[11:6], clock_hour[16:12], clock_day[21:17],
    // clock_month[25:22], clock_year[41:26], clock_weekday[44:42], zero[47:45]
    output logic [47:0] o_m_axis_tdata,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data
);

    cca_pkg::t_cmd      cmd;
    cca_pkg::t_status   status;
    cca_pkg::t_in_item  in_item;
    cca_pkg::t_out_item result;

    // unpack the incoming transaction
    assign in_item.operation      = i_s_axis_tuser;
    assign in_item.day_count      = i_s_axis_tdata[15:0];
    assign in_item.hour_count     = i_s_axis_tdata[23:16];
    assign in_item.minute_count   = i_s_axis_tdata[31:24];
    assign in_item.second_count   = i_s_axis_tdata[39:32];
    assign in_item.target_weekday = i_s_axis_tdata[42:40];

    // registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    cca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    cca_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_item      (in_item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (result)
    );

    // pack the outgoing transaction
    assign o_m_axis_tdata = {3'b000,
                             result.clock_weekday,
                             result.clock_year,
                             result.clock_month,
                             result.clock_day,
                             result.clock_hour,
                             result.clock_minute,
                             result.clock_second};

endmodule

// File: design/cca_checker.sv
module cca_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata
);

    // a pending result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped before it was taken");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // only one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready while an item is in work");

    // each delivered second, minute, hour, month and weekday lies within its legal range and the day is nonzero
    a_fields_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[5:0] < 6'd60) && (o_m_axis_tdata[11:6] < 6'd60)
            && (o_m_axis_tdata[16:12] < 5'd24) && (o_m_axis_tdata[21:17] != 5'd0)
            && (o_m_axis_tdata[25:22] != 4'd0) && (o_m_axis_tdata[25:22] < 4'd13)
            && (o_m_axis_tdata[44:42] != 3'd7))
        else $error("result holds an out-of-range clock field");

endmodule

bind calendar_clock_advance_core cca_checker u_cca_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
